// ===== design/pdtq_pkg.sv =====
// Package for the per-destination priority transmit queue.
// Sizes, command and status codes, and ring pointer helpers.
// No dependencies.
package pdtq_pkg;

  localparam int DESTINATIONS = 16;
  localparam int QUEUE_DEPTH  = 64;
  localparam int HANDLE_BITS  = 16;

  localparam int SLOT_W      = (DESTINATIONS > 1) ? $clog2(DESTINATIONS) : 1;
  localparam int SLOT_CMP_W  = 9;
  localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W       = PTR_W + 2;
  localparam int STORE_DEPTH = DESTINATIONS * QUEUE_DEPTH;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  localparam int CMD_W       = 3;
  localparam int SLOT_FIELD_W = 4;
  localparam int SIZE_W      = 16;
  localparam int OUT_HANDLE_W = 16;
  localparam int QSIZE_W     = 8;
  localparam int STATUS_W    = 2;
  localparam int RATIO_W     = 8;
  localparam int RETRY_W     = 7;
  localparam logic [RETRY_W-1:0] RETRY_MAX = '1;

  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_PRIO_ENABLED    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRIO_SIZE_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RATIO_PERIOD    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PRIO_SLOTS      = 2'd3;

  localparam logic [SIZE_W-1:0]  RST_PRIO_SIZE_LIMIT = 16'd128;
  localparam logic [RATIO_W-1:0] RST_RATIO_PERIOD    = 8'd10;
  localparam logic [RATIO_W-1:0] RST_PRIO_SLOTS      = 8'd5;

  // remainder unit: (counter + 1) mod period, one dividend bit per step
  localparam int DIVIDEND_W = RATIO_W + 1;
  localparam int MOD_STEPS  = DIVIDEND_W;
  localparam int STEP_W     = $clog2(MOD_STEPS + 1);

  typedef enum logic [CMD_W-1:0] {
    CMD_ENQUEUE   = 3'd0,
    CMD_REENQUEUE = 3'd1,
    CMD_PEEK      = 3'd2,
    CMD_POP       = 3'd3,
    CMD_CLEAR     = 3'd4,
    CMD_CLEAR_ALL = 3'd5,
    CMD_SIZE      = 3'd6
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_t;

  // per-transaction result info carried while the store read is in flight
  typedef struct packed {
    logic                rd;
    logic                cls;
    logic                retx;
    logic [QSIZE_W-1:0]  qsize;
    status_t             status;
  } result_t;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
    return (p == '0) ? PTR_W'(QUEUE_DEPTH - 1) : p - PTR_W'(1);
  endfunction

  // tail position: (head + count) mod depth, count below depth here
  function automatic logic [PTR_W-1:0] ring_idx(input logic [PTR_W-1:0] head,
                                                input logic [CNT_W-1:0] cnt);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(head) + SUM_W'(cnt);
    if (sum >= SUM_W'(QUEUE_DEPTH)) begin
      sum = sum - SUM_W'(QUEUE_DEPTH);
    end
    return sum[PTR_W-1:0];
  endfunction

  function automatic logic [ADDR_W-1:0] ram_addr(input logic [SLOT_W-1:0] slot,
                                                 input logic [PTR_W-1:0] idx);
    return ADDR_W'(slot) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(idx);
  endfunction

  function automatic logic [RETRY_W-1:0] inc_sat(input logic [RETRY_W-1:0] v);
    return (v == RETRY_MAX) ? v : v + RETRY_W'(1);
  endfunction

endpackage

// ===== design/per_destination_priority_tx_queue.sv =====
// Per-destination two-class transmit queue with ratio scheduling.
// Results pass through the store read (stage 1), then the output register; pointers update at accept.
// Throughput: one transaction per cycle while the result side is ready and the remainder unit is idle.
// A write of ratio_period holds in_ready low while the remainder unit runs.
// Reset (rst, synchronous): empties all slots, zeroes counters, loads config defaults.
// The handle stores are not cleared; entries are read only after being written.
module per_destination_priority_tx_queue (
  input  logic                               clk,
  input  logic                               rst,
  // configuration write port
  input  logic                               cfg_we,
  input  logic [pdtq_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pdtq_pkg::CFG_DATA_W-1:0]    cfg_data,
  // command channel
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [pdtq_pkg::CMD_W-1:0]         command,
  input  logic [pdtq_pkg::SLOT_FIELD_W-1:0]  dest_slot,
  input  logic [pdtq_pkg::SIZE_W-1:0]        packet_handle,
  input  logic [pdtq_pkg::SIZE_W-1:0]        packet_size,
  // result channel
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [pdtq_pkg::OUT_HANDLE_W-1:0]  out_handle,
  output logic                               from_priority,
  output logic                               retransmission,
  output logic [pdtq_pkg::QSIZE_W-1:0]       queue_size,
  output logic [pdtq_pkg::STATUS_W-1:0]      status
);

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic                           prio_enabled;
  logic [pdtq_pkg::SIZE_W-1:0]    prio_size_limit;
  logic [pdtq_pkg::RATIO_W-1:0]   ratio_period;
  logic [pdtq_pkg::RATIO_W-1:0]   prio_slots;

  always_ff @(posedge clk) begin
    if (rst) begin
      prio_enabled    <= 1'b1;
      prio_size_limit <= pdtq_pkg::RST_PRIO_SIZE_LIMIT;
      ratio_period    <= pdtq_pkg::RST_RATIO_PERIOD;
      prio_slots      <= pdtq_pkg::RST_PRIO_SLOTS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pdtq_pkg::CFG_PRIO_ENABLED:    prio_enabled    <= cfg_data[0];
        pdtq_pkg::CFG_PRIO_SIZE_LIMIT: prio_size_limit <= cfg_data;
        pdtq_pkg::CFG_RATIO_PERIOD:    ratio_period    <= cfg_data[pdtq_pkg::RATIO_W-1:0];
        pdtq_pkg::CFG_PRIO_SLOTS:      prio_slots      <= cfg_data[pdtq_pkg::RATIO_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Per-slot ring state (flops, one entry per destination)
  // ---------------------------------------------------------------------
  logic [pdtq_pkg::PTR_W-1:0]   prio_head          [pdtq_pkg::DESTINATIONS];
  logic [pdtq_pkg::CNT_W-1:0]   prio_count         [pdtq_pkg::DESTINATIONS];
  logic [pdtq_pkg::PTR_W-1:0]   normal_head        [pdtq_pkg::DESTINATIONS];
  logic [pdtq_pkg::CNT_W-1:0]   normal_count       [pdtq_pkg::DESTINATIONS];
  logic [pdtq_pkg::RETRY_W-1:0] prio_retry_count   [pdtq_pkg::DESTINATIONS];
  logic [pdtq_pkg::RETRY_W-1:0] normal_retry_count [pdtq_pkg::DESTINATIONS];
  logic [pdtq_pkg::RATIO_W-1:0] ratio_counter;

  // ---------------------------------------------------------------------
  // Pipeline control
  // stage 1 holds the result info while the store read completes,
  // stage 2 is the output register.
  // ---------------------------------------------------------------------
  logic               s1_valid;
  pdtq_pkg::result_t  s1_info;
  logic               out_load;
  logic               accept;
  logic               mod_busy;
  logic [pdtq_pkg::RATIO_W-1:0] mod_rem;

  assign out_load = s1_valid && (!out_valid || out_ready);
  assign in_ready = (!s1_valid || out_load) && !mod_busy;
  assign accept   = in_valid && in_ready;

  // ---------------------------------------------------------------------
  // Command decode and slot update, evaluated on the incoming transaction
  // ---------------------------------------------------------------------
  pdtq_pkg::cmd_t                cmd;
  logic [pdtq_pkg::SLOT_W-1:0]   sidx;
  logic                          slot_ok;
  logic                          to_prio;
  logic [pdtq_pkg::PTR_W-1:0]    ph, nh, ph_next, nh_next;
  logic [pdtq_pkg::CNT_W-1:0]    pc, nc, pc_next, nc_next;
  logic [pdtq_pkg::RETRY_W-1:0]  pr, nr, pr_next, nr_next;
  logic [pdtq_pkg::RATIO_W-1:0]  ratio_counter_next;
  logic [pdtq_pkg::DIVIDEND_W-1:0] ratio_inc;
  logic                          slot_wr;
  logic                          clear_all;
  logic                          prio_we, normal_we, prio_re, normal_re;
  logic [pdtq_pkg::ADDR_W-1:0]   waddr, raddr;
  logic                          pick_prio, pick_normal;
  pdtq_pkg::result_t             info;

  assign cmd     = pdtq_pkg::cmd_t'(command);
  assign sidx    = dest_slot[pdtq_pkg::SLOT_W-1:0];
  assign slot_ok = pdtq_pkg::SLOT_CMP_W'(dest_slot) < pdtq_pkg::SLOT_CMP_W'(pdtq_pkg::DESTINATIONS);
  assign to_prio = prio_enabled && (packet_size <= prio_size_limit);

  assign ph = prio_head[sidx];
  assign pc = prio_count[sidx];
  assign nh = normal_head[sidx];
  assign nc = normal_count[sidx];
  assign pr = prio_retry_count[sidx];
  assign nr = normal_retry_count[sidx];

  // scheduler: priority while inside the favored window, else normal first
  always_comb begin
    pick_prio   = 1'b0;
    pick_normal = 1'b0;
    priority if (prio_enabled && pc != '0 && ratio_counter < prio_slots) begin
      pick_prio = 1'b1;
    end else if (nc != '0) begin
      pick_normal = 1'b1;
    end else if (pc != '0) begin
      pick_prio = 1'b1;
    end
  end

  assign ratio_inc = pdtq_pkg::DIVIDEND_W'(ratio_counter) + pdtq_pkg::DIVIDEND_W'(1);

  always_comb begin
    ph_next   = ph;
    nh_next   = nh;
    pc_next   = pc;
    nc_next   = nc;
    pr_next   = pr;
    nr_next   = nr;
    ratio_counter_next = ratio_counter;
    slot_wr   = 1'b0;
    clear_all = 1'b0;
    prio_we   = 1'b0;
    normal_we = 1'b0;
    prio_re   = 1'b0;
    normal_re = 1'b0;
    waddr     = pdtq_pkg::ram_addr(sidx, pdtq_pkg::ring_idx(ph, pc));
    raddr     = pdtq_pkg::ram_addr(sidx, ph);
    info      = '0;
    info.status = pdtq_pkg::STATUS_OK;

    unique case (cmd)
      pdtq_pkg::CMD_ENQUEUE, pdtq_pkg::CMD_REENQUEUE: begin
        if (!slot_ok) begin
          info.status = pdtq_pkg::STATUS_FULL;
        end else if (to_prio) begin
          if (pc == pdtq_pkg::CNT_W'(pdtq_pkg::QUEUE_DEPTH)) begin
            info.status = pdtq_pkg::STATUS_FULL;
          end else begin
            // priority re-enqueue still goes to the back
            prio_we = 1'b1;
            pc_next = pc + pdtq_pkg::CNT_W'(1);
            if (cmd == pdtq_pkg::CMD_REENQUEUE) begin
              pr_next = pdtq_pkg::inc_sat(pr);
            end
            slot_wr = 1'b1;
          end
        end else begin
          if (nc == pdtq_pkg::CNT_W'(pdtq_pkg::QUEUE_DEPTH)) begin
            info.status = pdtq_pkg::STATUS_FULL;
          end else begin
            normal_we = 1'b1;
            if (cmd == pdtq_pkg::CMD_REENQUEUE) begin
              // normal re-enqueue jumps the line
              nh_next = pdtq_pkg::ptr_dec(nh);
              waddr   = pdtq_pkg::ram_addr(sidx, pdtq_pkg::ptr_dec(nh));
              nr_next = pdtq_pkg::inc_sat(nr);
            end else begin
              waddr = pdtq_pkg::ram_addr(sidx, pdtq_pkg::ring_idx(nh, nc));
            end
            nc_next = nc + pdtq_pkg::CNT_W'(1);
            slot_wr = 1'b1;
          end
        end
      end
      pdtq_pkg::CMD_PEEK, pdtq_pkg::CMD_POP: begin
        if (!slot_ok || !(pick_prio || pick_normal)) begin
          info.status = pdtq_pkg::STATUS_EMPTY;
        end else begin
          info.rd  = 1'b1;
          info.cls = pick_prio;
          prio_re  = pick_prio;
          normal_re = pick_normal;
          raddr    = pdtq_pkg::ram_addr(sidx, pick_prio ? ph : nh);
          if (cmd == pdtq_pkg::CMD_POP) begin
            slot_wr = 1'b1;
            priority if (ratio_period == '0) begin
              ratio_counter_next = '0;
            end else if (ratio_counter >= ratio_period) begin
              // counter left at or above a shortened period: precomputed wrap
              ratio_counter_next = mod_rem;
            end else if (ratio_inc == pdtq_pkg::DIVIDEND_W'(ratio_period)) begin
              ratio_counter_next = '0;
            end else begin
              ratio_counter_next = ratio_inc[pdtq_pkg::RATIO_W-1:0];
            end
            if (pick_prio) begin
              ph_next = pdtq_pkg::ptr_inc(ph);
              pc_next = pc - pdtq_pkg::CNT_W'(1);
              if (pr != '0) begin
                info.retx = 1'b1;
                pr_next   = pr - pdtq_pkg::RETRY_W'(1);
              end
            end else begin
              nh_next = pdtq_pkg::ptr_inc(nh);
              nc_next = nc - pdtq_pkg::CNT_W'(1);
              if (nr != '0) begin
                info.retx = 1'b1;
                nr_next   = nr - pdtq_pkg::RETRY_W'(1);
              end
            end
          end
        end
      end
      pdtq_pkg::CMD_CLEAR: begin
        if (slot_ok) begin
          ph_next = '0;
          nh_next = '0;
          pc_next = '0;
          nc_next = '0;
          pr_next = '0;
          nr_next = '0;
          slot_wr = 1'b1;
        end
      end
      pdtq_pkg::CMD_CLEAR_ALL: begin
        clear_all = 1'b1;
      end
      pdtq_pkg::CMD_SIZE: begin
        if (slot_ok) begin
          info.qsize = pdtq_pkg::QSIZE_W'(pdtq_pkg::SUM_W'(pc) + pdtq_pkg::SUM_W'(nc));
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < pdtq_pkg::DESTINATIONS; i++) begin
        prio_head[i]          <= '0;
        prio_count[i]         <= '0;
        normal_head[i]        <= '0;
        normal_count[i]       <= '0;
        prio_retry_count[i]   <= '0;
        normal_retry_count[i] <= '0;
      end
      ratio_counter <= '0;
    end else if (accept) begin
      if (clear_all) begin
        for (int i = 0; i < pdtq_pkg::DESTINATIONS; i++) begin
          prio_head[i]          <= '0;
          prio_count[i]         <= '0;
          normal_head[i]        <= '0;
          normal_count[i]       <= '0;
          prio_retry_count[i]   <= '0;
          normal_retry_count[i] <= '0;
        end
      end else if (slot_wr) begin
        prio_head[sidx]          <= ph_next;
        prio_count[sidx]         <= pc_next;
        normal_head[sidx]        <= nh_next;
        normal_count[sidx]       <= nc_next;
        prio_retry_count[sidx]   <= pr_next;
        normal_retry_count[sidx] <= nr_next;
      end
      ratio_counter <= ratio_counter_next;
    end
  end

  // ---------------------------------------------------------------------
  // Wrap value for a ratio counter that sits at or above a new period
  // ---------------------------------------------------------------------
  pdtq_mod u_mod (
    .clk       (clk),
    .rst       (rst),
    .start     (cfg_we && cfg_index == pdtq_pkg::CFG_RATIO_PERIOD),
    .dividend  (ratio_inc),
    .divisor   (cfg_data[pdtq_pkg::RATIO_W-1:0]),
    .busy      (mod_busy),
    .remainder (mod_rem)
  );

  // ---------------------------------------------------------------------
  // Handle stores
  // ---------------------------------------------------------------------
  logic [pdtq_pkg::HANDLE_BITS-1:0] prio_rdata, normal_rdata;
  logic [pdtq_pkg::HANDLE_BITS-1:0] wdata;

  assign wdata = packet_handle[pdtq_pkg::HANDLE_BITS-1:0];

  pdtq_ram #(
    .WIDTH (pdtq_pkg::HANDLE_BITS),
    .DEPTH (pdtq_pkg::STORE_DEPTH)
  ) u_prio_store (
    .clk   (clk),
    .we    (accept && prio_we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (accept && prio_re),
    .raddr (raddr),
    .rdata (prio_rdata)
  );

  pdtq_ram #(
    .WIDTH (pdtq_pkg::HANDLE_BITS),
    .DEPTH (pdtq_pkg::STORE_DEPTH)
  ) u_normal_store (
    .clk   (clk),
    .we    (accept && normal_we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (accept && normal_re),
    .raddr (raddr),
    .rdata (normal_rdata)
  );

  // ---------------------------------------------------------------------
  // Stage 1 and output register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (out_load) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_info <= info;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (s1_info.rd) begin
        out_handle <= pdtq_pkg::OUT_HANDLE_W'(s1_info.cls ? prio_rdata : normal_rdata);
      end else begin
        out_handle <= '0;
      end
      from_priority  <= s1_info.cls;
      retransmission <= s1_info.retx;
      queue_size     <= s1_info.qsize;
      status         <= s1_info.status;
    end
  end

endmodule

// ===== design/pdtq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pdtq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/pdtq_mod.sv =====
// Bit-serial remainder unit: dividend mod divisor, one dividend bit per cycle.
// Depends on pdtq_pkg.
module pdtq_mod (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [pdtq_pkg::DIVIDEND_W-1:0]  dividend,
  input  logic [pdtq_pkg::RATIO_W-1:0]     divisor,
  output logic                             busy,
  output logic [pdtq_pkg::RATIO_W-1:0]     remainder
);

  logic [pdtq_pkg::DIVIDEND_W-1:0] dvd;
  logic [pdtq_pkg::RATIO_W-1:0]    dvs;
  logic [pdtq_pkg::STEP_W-1:0]     steps;
  logic [pdtq_pkg::DIVIDEND_W-1:0] trial;

  // shift in the next dividend bit; remainder stays below a nonzero divisor
  assign trial = {remainder, dvd[pdtq_pkg::DIVIDEND_W-1]};
  assign busy  = (steps != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      steps <= '0;
    end else if (start) begin
      steps <= pdtq_pkg::STEP_W'(pdtq_pkg::MOD_STEPS);
    end else if (busy) begin
      steps <= steps - pdtq_pkg::STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd       <= dividend;
      dvs       <= divisor;
      remainder <= '0;
    end else if (busy) begin
      dvd <= {dvd[pdtq_pkg::DIVIDEND_W-2:0], 1'b0};
      if (trial >= pdtq_pkg::DIVIDEND_W'(dvs)) begin
        remainder <= pdtq_pkg::RATIO_W'(trial - pdtq_pkg::DIVIDEND_W'(dvs));
      end else begin
        remainder <= trial[pdtq_pkg::RATIO_W-1:0];
      end
    end
  end

endmodule

// ===== dv/per_destination_priority_tx_queue_tb.sv =====
// Self-checking testbench for the per-destination priority transmit queue.
// Drives random and directed commands and checks every result against an in-bench predictor.
// Depends on pdtq_pkg and per_destination_priority_tx_queue.
module per_destination_priority_tx_queue_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pdtq_pkg::*;

  // command 7 has no function; the block must answer it with all zeros
  localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [CMD_W-1:0]        command;
    logic [SLOT_FIELD_W-1:0] slot;
    logic [SIZE_W-1:0]       handle;
    logic [SIZE_W-1:0]       size;
  } cmd_item_t;

  typedef struct packed {
    logic [OUT_HANDLE_W-1:0] handle;
    logic                    prio;
    logic                    retx;
    logic [QSIZE_W-1:0]      qsize;
    logic [STATUS_W-1:0]     status;
  } tx_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                    cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [CFG_DATA_W-1:0]   cfg_data  = '0;
  logic                    in_valid  = 1'b0;
  logic                    in_ready;
  logic [CMD_W-1:0]        command       = '0;
  logic [SLOT_FIELD_W-1:0] dest_slot     = '0;
  logic [SIZE_W-1:0]       packet_handle = '0;
  logic [SIZE_W-1:0]       packet_size   = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic [OUT_HANDLE_W-1:0] out_handle;
  logic                    from_priority;
  logic                    retransmission;
  logic [QSIZE_W-1:0]      queue_size;
  logic [STATUS_W-1:0]     status;

  per_destination_priority_tx_queue u_top (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .command        (command),
    .dest_slot      (dest_slot),
    .packet_handle  (packet_handle),
    .packet_size    (packet_size),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_handle     (out_handle),
    .from_priority  (from_priority),
    .retransmission (retransmission),
    .queue_size     (queue_size),
    .status         (status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: our own copy of both rings per slot, their pointers,
  // the re-enqueue counters, the global pop phase and the register mirror.
  // ---------------------------------------------------------------------------
  logic [SIZE_W-1:0]  prio_ring   [DESTINATIONS][QUEUE_DEPTH];
  logic [SIZE_W-1:0]  normal_ring [DESTINATIONS][QUEUE_DEPTH];
  logic [PTR_W-1:0]   p_head [DESTINATIONS];
  logic [PTR_W-1:0]   n_head [DESTINATIONS];
  logic [CNT_W-1:0]   p_cnt  [DESTINATIONS];
  logic [CNT_W-1:0]   n_cnt  [DESTINATIONS];
  logic [RETRY_W-1:0] p_retry[DESTINATIONS];
  logic [RETRY_W-1:0] n_retry[DESTINATIONS];
  logic [RATIO_W-1:0] pop_phase;

  logic               m_prio_en;
  logic [SIZE_W-1:0]  m_size_limit;
  logic [RATIO_W-1:0] m_period;
  logic [RATIO_W-1:0] m_prio_slots;

  cmd_item_t  cmd_backlog[$];       // commands waiting for the driver
  tx_result_t expected_results[$];  // predictions for accepted commands, oldest first

  int items_sent   = 0;
  int results_seen = 0;
  int errors       = 0;
  int cycles       = 0;
  int cfg_settings = 0;
  int n_pops = 0, n_drops = 0, n_empty = 0, n_retx = 0;
  bit no_idle = 1'b0;               // phase with back-to-back traffic on both sides

  function automatic void empty_slot(input int s);
    p_head[s]  = '0;
    n_head[s]  = '0;
    p_cnt[s]   = '0;
    n_cnt[s]   = '0;
    p_retry[s] = '0;
    n_retry[s] = '0;
  endfunction

  // Applies one command to the predictor state and returns the result it must produce.
  function automatic tx_result_t queue_cmd_result(input cmd_item_t c);
    tx_result_t r;
    int s;
    logic use_prio;
    logic found;
    r = '0;
    s = int'(c.slot);
    case (c.command)
      CMD_ENQUEUE, CMD_REENQUEUE: begin
        if (m_prio_en && c.size <= m_size_limit) begin
          if (p_cnt[s] == CNT_W'(QUEUE_DEPTH)) begin
            r.status = STATUS_FULL;
          end else begin
            // priority class: re-enqueue goes to the back like a plain enqueue
            prio_ring[s][PTR_W'(p_head[s] + p_cnt[s][PTR_W-1:0])] = c.handle;
            p_cnt[s]++;
            if (c.command == CMD_REENQUEUE && p_retry[s] != '1) p_retry[s]++;
          end
        end else begin
          if (n_cnt[s] == CNT_W'(QUEUE_DEPTH)) begin
            r.status = STATUS_FULL;
          end else if (c.command == CMD_REENQUEUE) begin
            // normal class: re-enqueue pushes in front of the head
            n_head[s] = n_head[s] - PTR_W'(1);
            normal_ring[s][n_head[s]] = c.handle;
            n_cnt[s]++;
            if (n_retry[s] != '1) n_retry[s]++;
          end else begin
            normal_ring[s][PTR_W'(n_head[s] + n_cnt[s][PTR_W-1:0])] = c.handle;
            n_cnt[s]++;
          end
        end
        if (r.status == STATUS_FULL) n_drops++;
      end
      CMD_PEEK, CMD_POP: begin
        found = 1'b1;
        if (m_prio_en && p_cnt[s] != '0 && pop_phase < m_prio_slots) use_prio = 1'b1;
        else if (n_cnt[s] != '0) use_prio = 1'b0;
        else if (p_cnt[s] != '0) use_prio = 1'b1;
        else begin
          use_prio = 1'b0;
          found    = 1'b0;
        end
        if (!found) begin
          r.status = STATUS_EMPTY;
          n_empty++;
        end else begin
          r.prio   = use_prio;
          r.handle = use_prio ? prio_ring[s][p_head[s]] : normal_ring[s][n_head[s]];
          if (c.command == CMD_POP) begin
            n_pops++;
            // zero period pins the phase at 0
            pop_phase = (m_period == '0) ? '0 :
                        RATIO_W'((9'(pop_phase) + 9'd1) % 9'(m_period));
            if (use_prio) begin
              p_head[s]++;
              p_cnt[s]--;
              if (p_retry[s] != '0) begin
                r.retx = 1'b1;
                p_retry[s]--;
              end
            end else begin
              n_head[s]++;
              n_cnt[s]--;
              if (n_retry[s] != '0) begin
                r.retx = 1'b1;
                n_retry[s]--;
              end
            end
            if (r.retx) n_retx++;
          end
        end
      end
      CMD_CLEAR: empty_slot(s);
      CMD_CLEAR_ALL: begin
        for (int i = 0; i < DESTINATIONS; i++) empty_slot(i);
      end
      CMD_SIZE: r.qsize = QSIZE_W'(p_cnt[s]) + QSIZE_W'(n_cnt[s]);
      default: ;
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: holds each command until its transaction, predicts at acceptance,
  // then idles a random number of cycles before offering the next one.
  // ---------------------------------------------------------------------------
  int send_gap = 0;

  always @(posedge clk) begin
    logic       nxt_valid;
    cmd_item_t  nxt;
    tx_result_t pred;
    if (rst) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      nxt_valid = in_valid;
      if (in_valid && in_ready) begin
        pred = queue_cmd_result(cmd_item_t'({command, dest_slot, packet_handle, packet_size}));
        expected_results.insert(expected_results.size(), pred);
        nxt_valid = 1'b0;
        send_gap  = no_idle ? 0 : $urandom_range(0, 7);
      end
      if (!nxt_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (cmd_backlog.size() != 0) begin
          nxt = cmd_backlog[0];
          cmd_backlog.delete(0);
          nxt_valid = 1'b1;
          command       <= nxt.command;
          dest_slot     <= nxt.slot;
          packet_handle <= nxt.handle;
          packet_size   <= nxt.size;
        end
      end
      in_valid <= nxt_valid;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks each result transaction field by field against the oldest
  // prediction, then stalls the result side for a random count of cycles.
  // ---------------------------------------------------------------------------
  int stall_left = 0;

  always @(posedge clk) begin
    tx_result_t want;
    if (rst) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          $error("result with no command outstanding: out_handle %h status %0d",
                 out_handle, status);
          errors++;
        end else begin
          want = expected_results[0];
          expected_results.delete(0);
          if (out_handle !== want.handle) begin
            $error("out_handle: expected %h, actual %h", want.handle, out_handle);
            errors++;
          end
          if (from_priority !== want.prio) begin
            $error("from_priority: expected %b, actual %b", want.prio, from_priority);
            errors++;
          end
          if (retransmission !== want.retx) begin
            $error("retransmission: expected %b, actual %b", want.retx, retransmission);
            errors++;
          end
          if (queue_size !== want.qsize) begin
            $error("queue_size: expected %0d, actual %0d", want.qsize, queue_size);
            errors++;
          end
          if (status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, status);
            errors++;
          end
        end
        stall_left = no_idle ? 0 : $urandom_range(0, 7);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d of %0d results", cycles, results_seen, items_sent);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [SLOT_FIELD_W-1:0] slot,
                          input logic [SIZE_W-1:0] handle, input logic [SIZE_W-1:0] size);
    cmd_item_t item;
    item = '{cmd, slot, handle, size};
    cmd_backlog.insert(cmd_backlog.size(), item);
    items_sent++;
  endtask

  // Waits until every prediction is matched, plus a few cycles of settle time
  // so the block is idle before any register write.
  task automatic drain();
    while (results_seen != items_sent) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // One register write; set_config passes random upper data bits to show they are ignored.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      CFG_PRIO_ENABLED:    m_prio_en    = data[0];
      CFG_PRIO_SIZE_LIMIT: m_size_limit = data;
      CFG_RATIO_PERIOD:    m_period     = data[RATIO_W-1:0];
      CFG_PRIO_SLOTS:      m_prio_slots = data[RATIO_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input logic en, input logic [SIZE_W-1:0] limit,
                            input logic [RATIO_W-1:0] period, input logic [RATIO_W-1:0] slots);
    write_reg(CFG_PRIO_ENABLED,    {15'($urandom), en});
    write_reg(CFG_PRIO_SIZE_LIMIT, limit);
    write_reg(CFG_RATIO_PERIOD,    {8'($urandom), period});
    write_reg(CFG_PRIO_SLOTS,      {8'($urandom), slots});
    cfg_settings++;
  endtask

  // Mixed traffic concentrated on two slots so rings build up and drain.
  task automatic run_mixed(input int n);
    logic [SLOT_FIELD_W-1:0] hot_a, hot_b, s;
    logic [SIZE_W-1:0]       sz;
    int pick;
    hot_a = SLOT_FIELD_W'($urandom_range(0, DESTINATIONS - 1));
    hot_b = SLOT_FIELD_W'($urandom_range(0, DESTINATIONS - 1));
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 9);
      s = (pick < 4) ? hot_a : (pick < 8) ? hot_b : SLOT_FIELD_W'($urandom);
      case ($urandom_range(0, 3))
        0:       sz = SIZE_W'($urandom_range(0, 255));
        1:       sz = SIZE_W'($urandom);
        2:       sz = m_size_limit + SIZE_W'($urandom_range(0, 2)) - SIZE_W'(1);
        default: sz = SIZE_W'($urandom_range(0, 2000));
      endcase
      pick = $urandom_range(0, 99);
      if (pick < 28)      send_cmd(CMD_ENQUEUE,   s, SIZE_W'($urandom), sz);
      else if (pick < 40) send_cmd(CMD_REENQUEUE, s, SIZE_W'($urandom), sz);
      else if (pick < 50) send_cmd(CMD_PEEK,      s, SIZE_W'($urandom), sz);
      else if (pick < 75) send_cmd(CMD_POP,       s, SIZE_W'($urandom), sz);
      else if (pick < 79) send_cmd(CMD_CLEAR,     s, SIZE_W'($urandom), sz);
      else if (pick < 81) send_cmd(CMD_CLEAR_ALL, s, SIZE_W'($urandom), sz);
      else if (pick < 93) send_cmd(CMD_SIZE,      s, SIZE_W'($urandom), sz);
      else                send_cmd(CMD_UNUSED,    s, SIZE_W'($urandom), sz);
    end
  endtask

  // Loads one slot with enqueues (drops where a ring is full), then mostly pops it.
  task automatic run_fill(input int n);
    logic [SLOT_FIELD_W-1:0] s;
    logic [SIZE_W-1:0]       sz;
    int pick;
    s = SLOT_FIELD_W'($urandom_range(0, DESTINATIONS - 1));
    for (int i = 0; i < n; i++) begin
      sz = $urandom_range(0, 1) ? SIZE_W'($urandom_range(0, m_size_limit))
                                : SIZE_W'($urandom_range(m_size_limit, 65535));
      send_cmd(($urandom_range(0, 4) == 0) ? CMD_REENQUEUE : CMD_ENQUEUE,
               s, SIZE_W'($urandom), sz);
    end
    send_cmd(CMD_SIZE, s, '0, '0);
    for (int i = 0; i < n + 2; i++) begin
      pick = $urandom_range(0, 19);
      send_cmd((pick < 17) ? CMD_POP : (pick < 19) ? CMD_PEEK : CMD_SIZE,
               s, SIZE_W'($urandom), SIZE_W'($urandom));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    for (int i = 0; i < DESTINATIONS; i++) empty_slot(i);
    pop_phase    = '0;
    m_prio_en    = 1'b1;
    m_size_limit = RST_PRIO_SIZE_LIMIT;
    m_period     = RST_RATIO_PERIOD;
    m_prio_slots = RST_PRIO_SLOTS;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part under reset register values (limit 128, period 10, 5 slots).
    send_cmd(CMD_POP,       4'd0,  16'h0000, 16'h0000);  // empty slot
    send_cmd(CMD_PEEK,      4'd15, 16'hFFFF, 16'hFFFF);  // empty slot
    send_cmd(CMD_SIZE,      4'd0,  16'h0000, 16'h0000);
    send_cmd(CMD_ENQUEUE,   4'd0,  16'hFFFF, 16'h0000);  // priority
    send_cmd(CMD_ENQUEUE,   4'd0,  16'h0000, 16'd128);   // limit itself is priority
    send_cmd(CMD_ENQUEUE,   4'd0,  16'h1234, 16'd129);   // just over: normal
    send_cmd(CMD_ENQUEUE,   4'd0,  16'hA5A5, 16'hFFFF);  // normal
    send_cmd(CMD_REENQUEUE, 4'd0,  16'h5A5A, 16'd200);   // normal, lands at the front
    send_cmd(CMD_REENQUEUE, 4'd0,  16'h0F0F, 16'd5);     // priority, lands at the back
    send_cmd(CMD_SIZE,      4'd0,  16'h0000, 16'h0000);
    send_cmd(CMD_PEEK,      4'd0,  16'h0000, 16'h0000);
    for (int i = 0; i < 6; i++) send_cmd(CMD_POP, 4'd0, 16'h0000, 16'h0000);
    send_cmd(CMD_POP,       4'd0,  16'h0000, 16'h0000);  // drained again
    send_cmd(CMD_UNUSED,    4'd3,  16'hC3C3, 16'h3C3C);
    send_cmd(CMD_ENQUEUE,   4'd15, 16'hBEEF, 16'd10);
    send_cmd(CMD_CLEAR,     4'd15, 16'h0000, 16'h0000);
    send_cmd(CMD_SIZE,      4'd15, 16'h0000, 16'h0000);
    send_cmd(CMD_ENQUEUE,   4'd7,  16'h7777, 16'd1000);
    send_cmd(CMD_CLEAR_ALL, 4'd9,  16'h0000, 16'h0000);
    send_cmd(CMD_PEEK,      4'd7,  16'h0000, 16'h0000);  // cleared by clear-all
    drain();

    // Random part: each phase runs under its own register setting; the first
    // few hit the extremes (all priority, priority off, zero period, max slots).
    for (int ph = 0; ph < 14; ph++) begin
      case (ph)
        0: set_config(1'b1, 16'hFFFF, 8'd1,   8'd0);
        1: set_config(1'b0, 16'h0000, 8'd255, 8'd255);
        2: set_config(1'b1, 16'h0000, 8'd0,   8'd1);
        3: set_config(1'b1, 16'd128,  8'd255, 8'd255);
        default: set_config($urandom_range(0, 3) != 0,
                            $urandom_range(0, 1) ? SIZE_W'($urandom_range(0, 400))
                                                 : SIZE_W'($urandom),
                            $urandom_range(0, 3) != 0 ? RATIO_W'($urandom_range(1, 12))
                                                      : RATIO_W'($urandom_range(1, 255)),
                            RATIO_W'($urandom_range(0, 13)));
      endcase
      no_idle = (ph % 4 == 2);
      if (ph % 3 == 1) run_fill(70);
      else run_mixed(80);
      drain();
    end
    no_idle = 1'b0;

    repeat (10) @(posedge clk);
    if (expected_results.size() != 0) begin
      $error("%0d predicted results never arrived", expected_results.size());
      errors++;
    end

    $display("%0d commands checked over %0d register settings", results_seen, cfg_settings);
    $display("%0d pops (%0d retransmissions), %0d empty answers, %0d full-ring drops",
             n_pops, n_retx, n_empty, n_drops);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/pdtq_pkg.sv
design/pdtq_ram.sv
design/pdtq_mod.sv
design/per_destination_priority_tx_queue.sv
dv/per_destination_priority_tx_queue_tb.sv
